FILE: hdl/fwrdf_pkg.sv
// ----------------------------------------------------------------------------
// fwrdf_pkg
// Shared types, constants and helpers of the fixed-width radix digit formatter.
// ----------------------------------------------------------------------------
package fwrdf_pkg;

    // Text grid
    localparam int COLUMNS     = 16;
    localparam int LINES       = 4;
    localparam int MAX_RESULTS = 17;

    // Digit buffer depth: an accepted request never has more digits than columns
    localparam int DIGIT_SLOTS = COLUMNS;

    // Largest digit count whose top divisor still fits in 32 bits
    localparam int BIN_MAX_DIGITS = 32;
    localparam int DEC_MAX_DIGITS = 10;
    localparam int HEX_MAX_DIGITS = 8;

    // floor(x * REC10 / 2^35) == x / 10 for every 32-bit x
    localparam logic [31:0] REC10       = 32'hCCCC_CCCD;
    localparam int          REC10_SHIFT = 35;

    // Radix select codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;
    localparam logic [1:0] RADIX_BAD = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // ASCII
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPPER = 7'h41;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_NUL   = 7'h00;

    typedef enum logic [1:0] {
        SEL_ERR,
        SEL_SIGN,
        SEL_DIGIT
    } out_sel_t;

    typedef struct packed {
        logic     load;       // capture a new item
        logic     mul;        // reciprocal multiply for the decimal step
        logic     conv_step;  // extract one digit, least significant first
        logic     out_load;   // fill the result register
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic err;      // item is answered with a single error result
        logic decimal;  // working radix is ten
        logic sgn;      // sign character goes first
        logic cnt_one;  // digit counter is at its last step
    } dp_status_t;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit);
        logic [6:0] d7;
        d7 = {3'b000, digit};
        if (digit < 4'd10) begin
            return 7'(CH_ZERO + d7);
        end else begin
            return 7'(CH_UPPER + d7 - 7'd10);
        end
    endfunction

endpackage

FILE: hdl/fwrdf_dp.sv
// ----------------------------------------------------------------------------
// fwrdf_dp
// Datapath: argument check, digit extraction, digit buffer, result register.
// ----------------------------------------------------------------------------
module fwrdf_dp (
    input  logic                  aclk,
    input  fwrdf_pkg::ctrl_cmd_t  cmd,
    output fwrdf_pkg::dp_status_t status,
    input  logic [31:0]           s_value,
    input  logic [4:0]            s_digit_count,
    input  logic [1:0]            s_radix_select,
    input  logic                  s_signed_mode,
    input  logic [2:0]            s_text_line,
    input  logic [4:0]            s_start_column,
    output logic [6:0]            m_character,
    output logic [2:0]            m_out_line,
    output logic [4:0]            m_out_column,
    output logic [1:0]            m_status,
    output logic                  m_last
);

    // Working registers
    logic [31:0] work_reg;
    logic [28:0] quot_reg;
    logic [3:0]  digits_reg [fwrdf_pkg::DIGIT_SLOTS];
    logic [4:0]  cnt_reg;
    logic [4:0]  n_reg;
    logic [1:0]  rad_reg;
    logic        neg_reg;
    logic        sgn_reg;
    logic [2:0]  line_reg;
    logic [4:0]  col_reg;
    logic [1:0]  err_reg;

    // Result register
    logic [6:0]  char_reg;
    logic [2:0]  oline_reg;
    logic [4:0]  ocol_reg;
    logic [1:0]  ostat_reg;
    logic        olast_reg;

    // Argument check on the input ports
    logic [5:0]  span;
    logic [5:0]  total;
    logic        line_ok;
    logic        inv_s;
    logic        inv_u;
    logic        too_wide;
    logic [1:0]  rad_eff;
    logic [1:0]  chk;

    always_comb begin
        span    = {1'b0, s_start_column} + {1'b0, s_digit_count};
        total   = {1'b0, s_digit_count} + {5'd0, s_signed_mode};
        line_ok = (s_text_line != 3'd0) && (s_text_line <= 3'(fwrdf_pkg::LINES));
        inv_s   = (s_digit_count == 5'd0) || (s_start_column == 5'd0) ||
                  (span > 6'(fwrdf_pkg::COLUMNS)) || !line_ok;
        inv_u   = (s_digit_count == 5'd0) ||
                  ({1'b0, s_digit_count} > 6'(fwrdf_pkg::COLUMNS)) ||
                  (s_start_column == 5'd0) ||
                  (span > 6'(fwrdf_pkg::COLUMNS + 1)) ||
                  (s_radix_select == fwrdf_pkg::RADIX_BAD);
        rad_eff = s_signed_mode ? fwrdf_pkg::RADIX_DEC : s_radix_select;
        unique case (rad_eff)
            fwrdf_pkg::RADIX_BIN:
                too_wide = {1'b0, s_digit_count} > 6'(fwrdf_pkg::BIN_MAX_DIGITS);
            fwrdf_pkg::RADIX_DEC:
                too_wide = {1'b0, s_digit_count} > 6'(fwrdf_pkg::DEC_MAX_DIGITS);
            fwrdf_pkg::RADIX_HEX:
                too_wide = {1'b0, s_digit_count} > 6'(fwrdf_pkg::HEX_MAX_DIGITS);
            fwrdf_pkg::RADIX_BAD:
                too_wide = 1'b0;
        endcase
        priority if (s_signed_mode ? inv_s : inv_u) begin
            chk = fwrdf_pkg::ST_INVALID;
        end else if (too_wide || (total > 6'(fwrdf_pkg::MAX_RESULTS))) begin
            chk = fwrdf_pkg::ST_UNSUPPORTED;
        end else if (!line_ok) begin
            chk = fwrdf_pkg::ST_INVALID;
        end else begin
            chk = fwrdf_pkg::ST_OK;
        end
    end

    // Digit step: quotient and remainder by the working radix
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem10;
    logic [3:0]  digit;

    assign prod = {32'd0, work_reg} * {32'd0, fwrdf_pkg::REC10};

    always_comb begin
        rem10 = work_reg - {quot_reg, 3'b000} - {2'b00, quot_reg, 1'b0};
        unique case (rad_reg)
            fwrdf_pkg::RADIX_BIN: begin
                quot  = {1'b0, work_reg[31:1]};
                digit = {3'b000, work_reg[0]};
            end
            fwrdf_pkg::RADIX_HEX: begin
                quot  = {4'd0, work_reg[31:4]};
                digit = work_reg[3:0];
            end
            default: begin
                quot  = {3'd0, quot_reg};
                digit = rem10[3:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        priority if (cmd.load) begin
            work_reg <= (s_signed_mode && s_value[31]) ? (~s_value + 32'd1) : s_value;
            neg_reg  <= s_signed_mode && s_value[31];
            sgn_reg  <= s_signed_mode;
            rad_reg  <= rad_eff;
            n_reg    <= s_digit_count;
            cnt_reg  <= s_digit_count;
            line_reg <= s_text_line;
            col_reg  <= s_start_column;
            err_reg  <= chk;
        end else if (cmd.mul) begin
            quot_reg <= prod[63:fwrdf_pkg::REC10_SHIFT];
        end else if (cmd.conv_step) begin
            // newest digit enters at slot 0, so the top digit ends up there
            work_reg      <= quot;
            digits_reg[0] <= digit;
            for (int i = 1; i < fwrdf_pkg::DIGIT_SLOTS; i++) begin
                digits_reg[i] <= digits_reg[i - 1];
            end
            cnt_reg <= (cnt_reg == 5'd1) ? n_reg : 5'(cnt_reg - 5'd1);
        end else if (cmd.out_load) begin
            oline_reg <= line_reg;
            unique case (cmd.out_sel)
                fwrdf_pkg::SEL_ERR: begin
                    char_reg  <= fwrdf_pkg::CH_NUL;
                    ocol_reg  <= col_reg;
                    ostat_reg <= err_reg;
                    olast_reg <= 1'b1;
                end
                fwrdf_pkg::SEL_SIGN: begin
                    char_reg  <= neg_reg ? fwrdf_pkg::CH_MINUS : fwrdf_pkg::CH_PLUS;
                    ocol_reg  <= col_reg;
                    ostat_reg <= fwrdf_pkg::ST_OK;
                    olast_reg <= 1'b0;
                    col_reg   <= 5'(col_reg + 5'd1);
                end
                default: begin
                    char_reg  <= fwrdf_pkg::digit_to_ascii(digits_reg[0]);
                    ocol_reg  <= col_reg;
                    ostat_reg <= fwrdf_pkg::ST_OK;
                    olast_reg <= (cnt_reg == 5'd1);
                    col_reg   <= 5'(col_reg + 5'd1);
                    cnt_reg   <= 5'(cnt_reg - 5'd1);
                    for (int i = 0; i < fwrdf_pkg::DIGIT_SLOTS - 1; i++) begin
                        digits_reg[i] <= digits_reg[i + 1];
                    end
                    digits_reg[fwrdf_pkg::DIGIT_SLOTS - 1] <= 4'd0;
                end
            endcase
        end else begin
            work_reg <= work_reg;
        end
    end

    assign status.err     = (err_reg != fwrdf_pkg::ST_OK);
    assign status.decimal = (rad_reg == fwrdf_pkg::RADIX_DEC);
    assign status.sgn     = sgn_reg;
    assign status.cnt_one = (cnt_reg == 5'd1);

    assign m_character  = char_reg;
    assign m_out_line   = oline_reg;
    assign m_out_column = ocol_reg;
    assign m_status     = ostat_reg;
    assign m_last       = olast_reg;

endmodule

FILE: hdl/fwrdf_ctrl.sv
// ----------------------------------------------------------------------------
// fwrdf_ctrl
// Controller: sequences check, digit extraction and result emission.
// ----------------------------------------------------------------------------
module fwrdf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fwrdf_pkg::ctrl_cmd_t  cmd,
    input  fwrdf_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_DIG,
        S_SIGN,
        S_EMIT,
        S_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.out_sel  = fwrdf_pkg::SEL_DIGIT;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                priority if (status.err) begin
                    state_next = S_ERR;
                end else if (status.decimal) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_DIG;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIG;
            end
            S_DIG: begin
                cmd.conv_step = 1'b1;
                priority if (status.cnt_one) begin
                    state_next = status.sgn ? S_SIGN : S_EMIT;
                end else if (status.decimal) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_DIG;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fwrdf_pkg::SEL_SIGN;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fwrdf_pkg::SEL_DIGIT;
                    if (status.cnt_one) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fwrdf_pkg::SEL_ERR;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hdl/fixed_width_radix_digit_formatter.sv
// ----------------------------------------------------------------------------
// fixed_width_radix_digit_formatter
// Turns a 32-bit value into fixed-width ASCII digits tagged with text positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) takes one item: value, digit count, radix,
//   signed flag, text line and start column. The result channel
//   (m_valid/m_ready) returns one item per character, most significant digit
//   first, each with its line and column; m_last marks the final one. Signed
//   items send '+' or '-' ahead of the decimal magnitude. A bad request is
//   answered by a single item with status invalid or unsupported.
// Sequence:
//   One item is worked at a time. After acceptance the request is checked,
//   then digits are extracted least significant first (for decimal: multiply
//   by the reciprocal of ten, then remainder), then the characters are
//   emitted one by one as the receiver takes them. Error items skip digit
//   extraction.
// Reset and stall:
//   aresetn (synchronous, active low) drops any item in flight and clears
//   m_valid. A stalled receiver holds the result register; emission waits,
//   and the next input item is taken once the last result is registered.
// ----------------------------------------------------------------------------
module fixed_width_radix_digit_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic [4:0]  s_digit_count,
    input  logic [1:0]  s_radix_select,
    input  logic        s_signed_mode,
    input  logic [2:0]  s_text_line,
    input  logic [4:0]  s_start_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_character,
    output logic [2:0]  m_out_line,
    output logic [4:0]  m_out_column,
    output logic [1:0]  m_status,
    output logic        m_last
);

    fwrdf_pkg::ctrl_cmd_t  cmd;
    fwrdf_pkg::dp_status_t status;

    // Sequencer: owns both handshakes
    fwrdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Check, digit extraction and the result register
    fwrdf_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .s_value        (s_value),
        .s_digit_count  (s_digit_count),
        .s_radix_select (s_radix_select),
        .s_signed_mode  (s_signed_mode),
        .s_text_line    (s_text_line),
        .s_start_column (s_start_column),
        .m_character    (m_character),
        .m_out_line     (m_out_line),
        .m_out_column   (m_out_column),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    // Error items are single, closing, and carry no character
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != fwrdf_pkg::ST_OK) |-> m_last && (m_character == 7'd0))
        else $error("error item not final or has a character");

    // Good characters always carry a nonzero line and column
    a_ok_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fwrdf_pkg::ST_OK) |->
            (m_out_column != 5'd0) && (m_out_line != 3'd0))
        else $error("character outside the text grid");

    // The block is busy in the cycle after it takes an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accept");

    // Result status carries only the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == fwrdf_pkg::ST_OK) || (m_status == fwrdf_pkg::ST_INVALID) ||
            (m_status == fwrdf_pkg::ST_UNSUPPORTED))
        else $error("undefined status code");

endmodule
